// File: rtl/core/yd_pkg.sv
// Shared types and constants for the line deinterlacer.
package yd_pkg;

    // Configuration port
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 13;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIELD_PARITY = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPATIAL_EN   = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] RESET_LINE_WIDTH = 13'd720;

    // Line geometry
    localparam int unsigned MIN_WIDTH   = 7;
    localparam int unsigned MAX_WIDTH   = 4096;
    localparam int unsigned WINDOW_COLS = 7;
    localparam int unsigned EDGE_COLS   = 3;
    localparam int unsigned DELAY_COLS  = 4;
    // first column that has a full window behind it
    localparam int unsigned INNER_START = 6;
    // inner pixel plus the three closing edge pixels
    localparam int unsigned MAX_RESULTS = 4;

    typedef logic [CFG_DATA_BITS-1:0] t_count;

    // What one accepted column asks the output side to send
    typedef struct packed {
        logic vld;
        logic edge0;   // leading edge pixel (first three columns)
        logic inner;   // inner pixel of the window center
        logic last;    // last column: three closing edge pixels follow
    } t_job;

endpackage

// File: rtl/core/yd_window.sv
// Column window, delay lines, column counter and the pending column job.
module yd_window #(
    parameter int unsigned PIXEL_BITS = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_take,
    input  logic                                         i_pop,
    input  yd_pkg::t_count                               i_width,
    input  logic [PIXEL_BITS-1:0]                        i_cur_above,
    input  logic [PIXEL_BITS-1:0]                        i_cur_below,
    input  logic [PIXEL_BITS-1:0]                        i_prev_above,
    input  logic [PIXEL_BITS-1:0]                        i_prev_below,
    input  logic [PIXEL_BITS-1:0]                        i_next_above,
    input  logic [PIXEL_BITS-1:0]                        i_next_below,
    input  logic [PIXEL_BITS-1:0]                        i_cur_up_two,
    input  logic [PIXEL_BITS-1:0]                        i_cur_middle,
    input  logic [PIXEL_BITS-1:0]                        i_cur_down_two,
    input  logic [PIXEL_BITS-1:0]                        i_other_up_two,
    input  logic [PIXEL_BITS-1:0]                        i_other_middle,
    input  logic [PIXEL_BITS-1:0]                        i_other_down_two,
    output yd_pkg::t_job                                 o_job,
    output logic [yd_pkg::WINDOW_COLS-1:0][PIXEL_BITS-1:0] o_above,
    output logic [yd_pkg::WINDOW_COLS-1:0][PIXEL_BITS-1:0] o_below,
    output logic [3:0][PIXEL_BITS-1:0]                   o_nbr,
    output logic [2:0][PIXEL_BITS-1:0]                   o_early,
    output logic [2:0][PIXEL_BITS-1:0]                   o_late
);

    localparam int unsigned WC = yd_pkg::WINDOW_COLS;
    localparam int unsigned DC = yd_pkg::DELAY_COLS;

    logic [WC-1:0][PIXEL_BITS-1:0]       r_above;
    logic [WC-1:0][PIXEL_BITS-1:0]       r_below;
    logic [DC-1:0][3:0][PIXEL_BITS-1:0]  r_nbr;
    logic [DC-1:0][2:0][PIXEL_BITS-1:0]  r_early;
    logic [DC-1:0][2:0][PIXEL_BITS-1:0]  r_late;
    yd_pkg::t_count                      r_count;
    yd_pkg::t_job                        r_job;

    yd_pkg::t_count n_count;
    yd_pkg::t_job   n_job;

    always_comb begin
        n_job.vld   = 1'b1;
        n_job.edge0 = r_count < yd_pkg::t_count'(yd_pkg::EDGE_COLS);
        n_job.inner = r_count >= yd_pkg::t_count'(yd_pkg::INNER_START);
        // a width lowered mid-line also ends the line here
        n_job.last  = r_count >= (i_width - yd_pkg::t_count'(1));
        n_count     = n_job.last ? '0 : r_count + yd_pkg::t_count'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job   <= '0;
            r_count <= '0;
        end else if (i_take) begin
            r_job   <= n_job;
            r_count <= n_count;
        end else if (i_pop) begin
            r_job.vld <= 1'b0;
        end
    end

    // newest column enters at index 0
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_above <= {r_above[WC-2:0], i_cur_above};
            r_below <= {r_below[WC-2:0], i_cur_below};
            r_nbr   <= {r_nbr[DC-2:0],
                        {i_next_below, i_next_above, i_prev_below, i_prev_above}};
            r_early <= {r_early[DC-2:0], {i_cur_down_two, i_cur_middle, i_cur_up_two}};
            r_late  <= {r_late[DC-2:0],
                        {i_other_down_two, i_other_middle, i_other_up_two}};
        end
    end

    assign o_job   = r_job;
    assign o_above = r_above;
    assign o_below = r_below;
    assign o_nbr   = r_nbr[DC-1];
    assign o_early = r_early[DC-1];
    assign o_late  = r_late[DC-1];

endmodule

// File: rtl/core/yd_interp.sv
// Pixel math: edge-directed spatial prediction, temporal clamp, edge averages.
module yd_interp #(
    parameter int unsigned PIXEL_BITS = 8
) (
    input  logic [yd_pkg::WINDOW_COLS-1:0][PIXEL_BITS-1:0] i_above,
    input  logic [yd_pkg::WINDOW_COLS-1:0][PIXEL_BITS-1:0] i_below,
    input  logic [3:0][PIXEL_BITS-1:0]                     i_nbr,
    input  logic [2:0][PIXEL_BITS-1:0]                     i_early,
    input  logic [2:0][PIXEL_BITS-1:0]                     i_late,
    input  logic                                           i_field_parity,
    input  logic                                           i_spatial_en,
    output logic [PIXEL_BITS-1:0]                          o_inner,
    output logic [yd_pkg::EDGE_COLS-1:0][PIXEL_BITS-1:0]   o_edge
);

    // three absolute differences of pixels need PIXEL_BITS+2 bits plus sign
    localparam int unsigned SW = PIXEL_BITS + 3;

    typedef logic signed [SW-1:0] t_sval;

    function automatic t_sval ext(input logic [PIXEL_BITS-1:0] v);
        return $signed({3'b000, v});
    endfunction

    function automatic t_sval absd(input t_sval a, input t_sval b);
        t_sval diff;
        diff = a - b;
        return (diff < 0) ? -diff : diff;
    endfunction

    function automatic t_sval smax(input t_sval a, input t_sval b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_sval smin(input t_sval a, input t_sval b);
        return (a < b) ? a : b;
    endfunction

    t_sval u [yd_pkg::WINDOW_COLS];
    t_sval dn [yd_pkg::WINDOW_COLS];
    t_sval c, e;
    t_sval pa, pb, qa, qb;
    t_sval cu, cm, cd, ou, om, od;
    t_sval d, t0, t1, t2, lim, lim_sp;
    t_sval b, f, hi, lo;
    t_sval s1, s2, s3, s4;
    t_sval best, pred;
    t_sval clamped;
    logic [PIXEL_BITS:0] edge_sum [yd_pkg::EDGE_COLS];

    always_comb begin
        for (int i = 0; i < int'(yd_pkg::WINDOW_COLS); i++) begin
            u[i]  = ext(i_above[i]);
            dn[i] = ext(i_below[i]);
        end
        // index 3 is the window center; index 3-j is column center+j
        c = u[3];
        e = dn[3];

        // paired frame first; the temporal limit is symmetric in the two
        if (i_field_parity) begin
            pa = ext(i_nbr[0]);
            pb = ext(i_nbr[1]);
            qa = ext(i_nbr[2]);
            qb = ext(i_nbr[3]);
        end else begin
            pa = ext(i_nbr[2]);
            pb = ext(i_nbr[3]);
            qa = ext(i_nbr[0]);
            qb = ext(i_nbr[1]);
        end
        cu = ext(i_early[0]);
        cm = ext(i_early[1]);
        cd = ext(i_early[2]);
        ou = ext(i_late[0]);
        om = ext(i_late[1]);
        od = ext(i_late[2]);

        d   = (cm + om) >>> 1;
        t0  = absd(cm, om) >>> 1;
        t1  = (absd(pa, c) + absd(pb, e)) >>> 1;
        t2  = (absd(qa, c) + absd(qb, e)) >>> 1;
        lim = smax(smax(t0, t1), t2);

        // vertical direction carries a bias of one in its favor
        best = absd(u[4], dn[4]) + absd(c, e) + absd(u[2], dn[2]) - t_sval'(1);
        pred = (c + e) >>> 1;

        s1 = absd(u[5], dn[3]) + absd(u[4], dn[2]) + absd(u[3], dn[1]);
        s2 = absd(u[6], dn[2]) + absd(u[5], dn[1]) + absd(u[4], dn[0]);
        s3 = absd(u[3], dn[5]) + absd(u[2], dn[4]) + absd(u[1], dn[3]);
        s4 = absd(u[2], dn[6]) + absd(u[1], dn[5]) + absd(u[0], dn[4]);

        // steeper angle is tried only when the shallower one won
        if (s1 < best) begin
            best = s1;
            pred = (u[4] + dn[2]) >>> 1;
            if (s2 < best) begin
                best = s2;
                pred = (u[5] + dn[1]) >>> 1;
            end
        end
        if (s3 < best) begin
            best = s3;
            pred = (u[2] + dn[4]) >>> 1;
            if (s4 < best) begin
                best = s4;
                pred = (u[1] + dn[5]) >>> 1;
            end
        end

        b  = (cu + ou) >>> 1;
        f  = (cd + od) >>> 1;
        hi = smax(smax(d - e, d - c), smin(b - c, f - e));
        lo = smin(smin(d - e, d - c), smax(b - c, f - e));
        lim_sp = i_spatial_en ? smax(smax(lim, lo), -hi) : lim;

        clamped = smax(smin(pred, d + lim_sp), d - lim_sp);
        o_inner = clamped[PIXEL_BITS-1:0];

        for (int i = 0; i < int'(yd_pkg::EDGE_COLS); i++) begin
            edge_sum[i] = {1'b0, i_above[i]} + {1'b0, i_below[i]} + (PIXEL_BITS+1)'(1);
            o_edge[i]   = edge_sum[i][PIXEL_BITS:1];
        end
    end

endmodule

// File: rtl/core/yd_emit.sv
// Result register queue: sends the up to four pixels of a column in order.
module yd_emit #(
    parameter int unsigned PIXEL_BITS = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  yd_pkg::t_job                                 i_job,
    input  logic [PIXEL_BITS-1:0]                        i_inner,
    input  logic [yd_pkg::EDGE_COLS-1:0][PIXEL_BITS-1:0] i_edge,
    input  logic                                         i_ready,
    output logic                                         o_load,
    output logic                                         o_valid,
    output logic [PIXEL_BITS-1:0]                        o_pixel,
    output logic                                         o_line_end
);

    localparam int unsigned QD = yd_pkg::MAX_RESULTS;
    localparam int unsigned LW = $clog2(QD + 1);

    logic [QD-1:0][PIXEL_BITS-1:0] r_q;
    logic [LW-1:0]                 r_left;
    logic                          r_end;

    logic [QD-1:0][PIXEL_BITS-1:0] n_q;
    logic [LW-1:0]                 n_left;
    logic                          n_end;
    logic                          w_free;

    // room once the last queued pixel leaves in this cycle
    assign w_free = (r_left == '0) || ((r_left == LW'(1)) && i_ready);
    assign o_load = i_job.vld && w_free;

    always_comb begin
        n_q    = r_q;
        n_left = r_left;
        n_end  = r_end;
        if ((r_left != '0) && i_ready) begin
            for (int i = 0; i < int'(QD) - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
            n_left = r_left - LW'(1);
        end
        if (o_load) begin
            // a last column always has an inner pixel ahead of the edges
            n_q[0] = i_job.edge0 ? i_edge[0] : i_inner;
            n_q[1] = i_edge[2];
            n_q[2] = i_edge[1];
            n_q[3] = i_edge[0];
            n_end  = i_job.last;
            if (i_job.last) begin
                n_left = LW'(QD);
            end else if (i_job.edge0 || i_job.inner) begin
                n_left = LW'(1);
            end else begin
                n_left = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_end  <= 1'b0;
        end else begin
            r_left <= n_left;
            r_end  <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_valid    = r_left != '0;
    assign o_pixel    = r_q[0];
    assign o_line_end = r_end && (r_left == LW'(1));

endmodule

// File: rtl/core/yadif_deinterlace_line.sv
// A column passes the window registers and then the output queue registers.
// Throughput: one column per cycle while the output is ready; the last column
// of a line sends four pixels from the output queue, so input stalls while they drain.
// Columns 3 to 5 of a line produce no pixel (window fill).
// Reset (synchronous, active low) clears the counter, job and queue state and
// sets line_width 720, field_parity 0, spatial_check_enable 1.
module yadif_deinterlace_line #(
    parameter int unsigned PIXEL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [yd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [yd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // column input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [PIXEL_BITS-1:0]               i_cur_above,
    input  logic [PIXEL_BITS-1:0]               i_cur_below,
    input  logic [PIXEL_BITS-1:0]               i_prev_above,
    input  logic [PIXEL_BITS-1:0]               i_prev_below,
    input  logic [PIXEL_BITS-1:0]               i_next_above,
    input  logic [PIXEL_BITS-1:0]               i_next_below,
    input  logic [PIXEL_BITS-1:0]               i_cur_up_two,
    input  logic [PIXEL_BITS-1:0]               i_cur_middle,
    input  logic [PIXEL_BITS-1:0]               i_cur_down_two,
    input  logic [PIXEL_BITS-1:0]               i_other_up_two,
    input  logic [PIXEL_BITS-1:0]               i_other_middle,
    input  logic [PIXEL_BITS-1:0]               i_other_down_two,
    // pixel output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [PIXEL_BITS-1:0]               o_pixel,
    output logic                                o_line_end
);

    yd_pkg::t_count r_line_width;
    logic           r_field_parity;
    logic           r_spatial_en;

    yd_pkg::t_count w_width;
    logic           w_take;
    logic           w_load;
    yd_pkg::t_job   w_job;

    logic [yd_pkg::WINDOW_COLS-1:0][PIXEL_BITS-1:0] w_above;
    logic [yd_pkg::WINDOW_COLS-1:0][PIXEL_BITS-1:0] w_below;
    logic [3:0][PIXEL_BITS-1:0]                     w_nbr;
    logic [2:0][PIXEL_BITS-1:0]                     w_early;
    logic [2:0][PIXEL_BITS-1:0]                     w_late;
    logic [PIXEL_BITS-1:0]                          w_inner;
    logic [yd_pkg::EDGE_COLS-1:0][PIXEL_BITS-1:0]   w_edge;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= yd_pkg::RESET_LINE_WIDTH;
            r_field_parity <= 1'b0;
            r_spatial_en   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                yd_pkg::CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                yd_pkg::CFG_FIELD_PARITY: r_field_parity <= i_cfg_data[0];
                yd_pkg::CFG_SPATIAL_EN:   r_spatial_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_line_width < yd_pkg::t_count'(yd_pkg::MIN_WIDTH)) begin
            w_width = yd_pkg::t_count'(yd_pkg::MIN_WIDTH);
        end else if (r_line_width > yd_pkg::t_count'(yd_pkg::MAX_WIDTH)) begin
            w_width = yd_pkg::t_count'(yd_pkg::MAX_WIDTH);
        end else begin
            w_width = r_line_width;
        end
    end

    // the pending job must move to the output queue before the window shifts
    assign o_ready = !w_job.vld || w_load;
    assign w_take  = i_valid && o_ready;

    yd_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (w_take),
        .i_pop            (w_load),
        .i_width          (w_width),
        .i_cur_above      (i_cur_above),
        .i_cur_below      (i_cur_below),
        .i_prev_above     (i_prev_above),
        .i_prev_below     (i_prev_below),
        .i_next_above     (i_next_above),
        .i_next_below     (i_next_below),
        .i_cur_up_two     (i_cur_up_two),
        .i_cur_middle     (i_cur_middle),
        .i_cur_down_two   (i_cur_down_two),
        .i_other_up_two   (i_other_up_two),
        .i_other_middle   (i_other_middle),
        .i_other_down_two (i_other_down_two),
        .o_job            (w_job),
        .o_above          (w_above),
        .o_below          (w_below),
        .o_nbr            (w_nbr),
        .o_early          (w_early),
        .o_late           (w_late)
    );

    yd_interp #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_interp (
        .i_above        (w_above),
        .i_below        (w_below),
        .i_nbr          (w_nbr),
        .i_early        (w_early),
        .i_late         (w_late),
        .i_field_parity (r_field_parity),
        .i_spatial_en   (r_spatial_en),
        .o_inner        (w_inner),
        .o_edge         (w_edge)
    );

    yd_emit #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_job),
        .i_inner    (w_inner),
        .i_edge     (w_edge),
        .i_ready    (i_ready),
        .o_load     (w_load),
        .o_valid    (o_valid),
        .o_pixel    (o_pixel),
        .o_line_end (o_line_end)
    );

endmodule

// File: tb/sv/yadif_deinterlace_line_test.sv
// Self-checking testbench for the deinterlacer line core: predicted pixels vs. streamed output.
module yadif_deinterlace_line_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX = 8;
    localparam logic [yd_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_COLUMNS = 56;
    localparam int PHASES        = 8;
    localparam int WIDE_COLUMNS  = 12;

    typedef logic [PIX-1:0] t_pix;

    typedef struct packed {
        t_pix cur_above;
        t_pix cur_below;
        t_pix prev_above;
        t_pix prev_below;
        t_pix next_above;
        t_pix next_below;
        t_pix cur_up_two;
        t_pix cur_middle;
        t_pix cur_down_two;
        t_pix other_up_two;
        t_pix other_middle;
        t_pix other_down_two;
    } t_column;

    typedef struct packed {
        t_pix pixel;
        logic line_end;
    } t_out_pixel;

    class line_scoreboard;
        yd_pkg::t_count width_reg;
        logic           parity_reg;
        logic           spatial_on;
        t_pix           above_win[yd_pkg::WINDOW_COLS];
        t_pix           below_win[yd_pkg::WINDOW_COLS];
        t_column        delayed[yd_pkg::DELAY_COLS];
        yd_pkg::t_count column_idx;
        t_out_pixel     expected_pixels[$];
        int             mismatches;
        int             columns_seen;
        int             pixels_checked;
        int             lines_closed;

        function new();
            width_reg = yd_pkg::RESET_LINE_WIDTH;
            parity_reg = 1'b0;
            spatial_on = 1'b1;
            column_idx = '0;
            foreach (above_win[i]) begin
                above_win[i] = '0;
                below_win[i] = '0;
            end
            foreach (delayed[i]) delayed[i] = '0;
            mismatches = 0;
            columns_seen = 0;
            pixels_checked = 0;
            lines_closed = 0;
        endfunction

        function void set_register(logic [yd_pkg::CFG_INDEX_BITS-1:0] idx,
                                   yd_pkg::t_count data);
            case (idx)
                yd_pkg::CFG_LINE_WIDTH:   width_reg = data;
                yd_pkg::CFG_FIELD_PARITY: parity_reg = data[0];
                yd_pkg::CFG_SPATIAL_EN:   spatial_on = data[0];
                default: ;
            endcase
        endfunction

        function int absdiff(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int larger(int a, int b);
            return (a > b) ? a : b;
        endfunction

        function int smaller(int a, int b);
            return (a < b) ? a : b;
        endfunction

        // rows y-1 / y+1 at offset j from the window center
        function int up(int j);
            return int'(above_win[3 - j]);
        endfunction

        function int dn(int j);
            return int'(below_win[3 - j]);
        endfunction

        function t_pix edge_avg(int pos);
            int sum;
            sum = int'(above_win[pos]) + int'(below_win[pos]) + 1;
            return t_pix'(sum >> 1);
        endfunction

        function t_pix interpolate();
            int c, e, d, lim, pred, best, s, b, f, hi, lo;
            t_column h;
            h = delayed[yd_pkg::DELAY_COLS-1];
            c = up(0);
            e = dn(0);
            d = (int'(h.cur_middle) + int'(h.other_middle)) >> 1;
            lim = larger(absdiff(int'(h.cur_middle), int'(h.other_middle)) >> 1,
                         larger((absdiff(int'(h.prev_above), c)
                                 + absdiff(int'(h.prev_below), e)) >> 1,
                                (absdiff(int'(h.next_above), c)
                                 + absdiff(int'(h.next_below), e)) >> 1));

            // vertical score carries a bias of one
            pred = (c + e) >> 1;
            best = absdiff(up(-1), dn(-1)) + absdiff(c, e) + absdiff(up(1), dn(1)) - 1;
            s = absdiff(up(-2), dn(0)) + absdiff(up(-1), dn(1)) + absdiff(up(0), dn(2));
            if (s < best) begin
                best = s;
                pred = (up(-1) + dn(1)) >> 1;
                s = absdiff(up(-3), dn(1)) + absdiff(up(-2), dn(2)) + absdiff(up(-1), dn(3));
                if (s < best) begin
                    best = s;
                    pred = (up(-2) + dn(2)) >> 1;
                end
            end
            s = absdiff(up(0), dn(-2)) + absdiff(up(1), dn(-1)) + absdiff(up(2), dn(0));
            if (s < best) begin
                best = s;
                pred = (up(1) + dn(-1)) >> 1;
                s = absdiff(up(1), dn(-3)) + absdiff(up(2), dn(-2)) + absdiff(up(3), dn(-1));
                if (s < best) begin
                    best = s;
                    pred = (up(2) + dn(-2)) >> 1;
                end
            end

            if (spatial_on) begin
                b = (int'(h.cur_up_two) + int'(h.other_up_two)) >> 1;
                f = (int'(h.cur_down_two) + int'(h.other_down_two)) >> 1;
                hi = larger(larger(d - e, d - c), smaller(b - c, f - e));
                lo = smaller(smaller(d - e, d - c), larger(b - c, f - e));
                lim = larger(larger(lim, lo), -hi);
            end
            return t_pix'(larger(smaller(pred, d + lim), d - lim));
        endfunction

        function void push(t_pix p, logic le);
            expected_pixels.push_back('{pixel: p, line_end: le});
        endfunction

        function void note_column(t_column col);
            int unsigned w;
            bit last;
            w = 32'(width_reg);
            if (w < yd_pkg::MIN_WIDTH) w = yd_pkg::MIN_WIDTH;
            if (w > yd_pkg::MAX_WIDTH) w = yd_pkg::MAX_WIDTH;
            for (int i = yd_pkg::WINDOW_COLS - 1; i > 0; i--) begin
                above_win[i] = above_win[i-1];
                below_win[i] = below_win[i-1];
            end
            above_win[0] = col.cur_above;
            below_win[0] = col.cur_below;
            for (int i = yd_pkg::DELAY_COLS - 1; i > 0; i--) delayed[i] = delayed[i-1];
            delayed[0] = col;

            columns_seen++;
            last = column_idx >= w - 1;
            if (column_idx < yd_pkg::EDGE_COLS) push(edge_avg(0), 1'b0);
            if (column_idx >= yd_pkg::INNER_START) push(interpolate(), 1'b0);
            if (last) begin
                // closing edge pixels, oldest column first
                for (int p = yd_pkg::EDGE_COLS - 1; p >= 0; p--) push(edge_avg(p), p == 0);
                column_idx = '0;
                lines_closed++;
            end else begin
                column_idx = column_idx + 1'b1;
            end
        endfunction

        function void check_pixel(t_pix px, logic le);
            t_out_pixel want;
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected pixel %0d line_end %0b", $time, px, le);
                return;
            end
            want = expected_pixels.pop_front();
            if (px !== want.pixel || le !== want.line_end) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: pixel #%0d expected %0d/%0b, got %0d/%0b (pixel/line_end)",
                             $time, pixels_checked, want.pixel, want.line_end, px, le);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [yd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [yd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;
    logic i_valid;
    logic o_ready;
    t_pix i_cur_above, i_cur_below, i_prev_above, i_prev_below, i_next_above, i_next_below;
    t_pix i_cur_up_two, i_cur_middle, i_cur_down_two;
    t_pix i_other_up_two, i_other_middle, i_other_down_two;
    logic o_valid;
    logic i_ready;
    t_pix o_pixel;
    logic o_line_end;

    line_scoreboard board;
    bit src_idle;
    bit sink_stalls;
    int cycle_count = 0;
    int config_writes;

    yadif_deinterlace_line #(
        .PIXEL_BITS(PIX)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cur_above     (i_cur_above),
        .i_cur_below     (i_cur_below),
        .i_prev_above    (i_prev_above),
        .i_prev_below    (i_prev_below),
        .i_next_above    (i_next_above),
        .i_next_below    (i_next_below),
        .i_cur_up_two    (i_cur_up_two),
        .i_cur_middle    (i_cur_middle),
        .i_cur_down_two  (i_cur_down_two),
        .i_other_up_two  (i_other_up_two),
        .i_other_middle  (i_other_middle),
        .i_other_down_two(i_other_down_two),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel         (o_pixel),
        .o_line_end      (o_line_end)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_pixel(o_pixel, o_line_end);
    end

    // output side back-pressure
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    function automatic t_pix near(int base);
        int v;
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return t_pix'(v);
    endfunction

    function automatic t_column make_column(int pos, int slope);
        t_column col;
        logic [12*PIX-1:0] bits;
        int style, base;
        t_pix lo, hi;
        style = $urandom_range(0, 9);
        base = $urandom_range(0, 255);
        lo = t_pix'($urandom_range(0, 127));
        hi = t_pix'($urandom_range(128, 255));
        col = t_column'({$urandom, $urandom, $urandom});
        case (style)
            3, 4: begin
                // flat area: scores close together
                for (int k = 0; k < 12; k++) bits[k*PIX +: PIX] = near(base);
                col = t_column'(bits);
            end
            5, 6: begin
                // slanted stripes between rows y-1 and y+1
                col.cur_above = ((pos + slope + 12) % 6 < 3) ? lo : hi;
                col.cur_below = ((pos - slope + 12) % 6 < 3) ? lo : hi;
            end
            7: begin
                for (int k = 0; k < 12; k++) bits[k*PIX +: PIX] = $urandom_range(0, 1) ? '1 : '0;
                col = t_column'(bits);
            end
            8: begin
                col.cur_above = near(base);
                col.cur_below = near(base);
            end
            9: begin
                // tight temporal range so the clamp bites
                col.cur_middle = near(base);
                col.other_middle = near(base);
                col.prev_above = near(base);
                col.prev_below = near(base);
                col.next_above = near(base);
                col.next_below = near(base);
            end
            default: ;
        endcase
        return col;
    endfunction

    task automatic put_column(t_column col);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {i_cur_above, i_cur_below, i_prev_above, i_prev_below, i_next_above, i_next_below,
         i_cur_up_two, i_cur_middle, i_cur_down_two,
         i_other_up_two, i_other_middle, i_other_down_two} <= col;
        do @(posedge i_clk); while (!o_ready);
        board.note_column(col);
        @(negedge i_clk);
    endtask

    task automatic write_register(logic [yd_pkg::CFG_INDEX_BITS-1:0] idx,
                                  yd_pkg::t_count data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, data);
        config_writes++;
        @(negedge i_clk);
    endtask

    // columns 3..5 give no pixel; wait until no expected pixel is left, then let the core idle
    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_settings(yd_pkg::t_count width, logic parity, logic spatial);
        yd_pkg::t_count junk;
        settle();
        write_register(yd_pkg::CFG_LINE_WIDTH, width);
        junk = yd_pkg::t_count'($urandom);
        junk[0] = parity;
        write_register(yd_pkg::CFG_FIELD_PARITY, junk);
        junk = yd_pkg::t_count'($urandom);
        junk[0] = spatial;
        write_register(yd_pkg::CFG_SPATIAL_EN, junk);
        if ($urandom_range(0, 2) == 0) write_register(CFG_UNUSED, yd_pkg::t_count'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_column col;
        yd_pkg::t_count width;
        int slope;

        board = new();
        config_writes = 0;
        src_idle = 1'b0;
        sink_stalls = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        {i_cur_above, i_cur_below, i_prev_above, i_prev_below, i_next_above, i_next_below,
         i_cur_up_two, i_cur_middle, i_cur_down_two,
         i_other_up_two, i_other_middle, i_other_down_two} = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: width 0 acts as the minimum line of 7
        apply_settings('0, 1'b0, 1'b1);
        for (int i = 0; i < 7; i++) put_column((i % 2) ? t_column'('1) : t_column'('0));

        // one-column slant, wide temporal range
        for (int i = 0; i < 7; i++) begin
            col = t_column'({12{8'd128}});
            col.cur_above = (i >= 4) ? 8'd255 : 8'd0;
            col.cur_below = (i >= 2) ? 8'd255 : 8'd0;
            col.cur_middle = 8'd0;
            col.other_middle = 8'd255;
            put_column(col);
        end

        // two-column slant the other way, spatial check off
        apply_settings(yd_pkg::t_count'(yd_pkg::MIN_WIDTH), 1'b1, 1'b0);
        for (int i = 0; i < 7; i++) begin
            col = t_column'({12{8'd64}});
            col.cur_above = (i >= 1) ? 8'd255 : 8'd0;
            col.cur_below = (i >= 5) ? 8'd255 : 8'd0;
            col.cur_up_two = 8'd255;
            col.other_down_two = 8'd255;
            put_column(col);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: width = yd_pkg::t_count'(yd_pkg::MIN_WIDTH);
                1: width = yd_pkg::t_count'($urandom_range(8, 16));
                2: width = yd_pkg::t_count'(40);
                3: width = yd_pkg::t_count'(10);   // phase 2 ends mid-line, next column closes it
                4: width = yd_pkg::t_count'(3);
                5: width = yd_pkg::t_count'($urandom_range(17, 64));
                6: width = yd_pkg::t_count'(8);
                default: width = yd_pkg::t_count'($urandom_range(7, 30));
            endcase
            apply_settings(width, 1'($urandom_range(0, 1)), ph % 3 != 1);
            src_idle = ph < 6;
            sink_stalls = ph < 6;
            slope = int'($urandom_range(0, 4)) - 2;
            for (int i = 0; i < PHASE_COLUMNS; i++) put_column(make_column(i, slope));

            if (ph == 5) begin
                // widest setting acts as the maximum line; a short burst stays mid-line,
                // and the narrow width of the next phase closes it
                apply_settings('1, 1'b0, 1'b1);
                src_idle = 1'b0;
                sink_stalls = 1'b0;
                for (int i = 0; i < WIDE_COLUMNS; i++) put_column(make_column(i, slope));
            end
        end

        settle();
        $display("Covered %0d columns in %0d closed lines, %0d pixels checked, %0d register writes",
                 board.columns_seen, board.lines_closed, board.pixels_checked, config_writes);
        $display("Widths from below minimum to above maximum, spatial check on and off, stalls");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
